/* hw/rtl/lptx_pkg.sv */
// Shared types, constants and lookup tables of the lidar packet decoder.
package lptx_pkg;

    localparam int BLOCKS_PER_PACKET = 12;
    localparam int BYTES_PER_BLOCK   = 100;
    localparam int RETURNS_PER_BLOCK = 32;
    localparam int LASERS_USED       = 16;

    localparam int CORDIC_STEPS = 16;
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;
    localparam logic [10:0] POS_MAX = 11'd2047;
    localparam logic [15:0] AZ_FULL = 16'd36000;
    localparam logic [15:0] AZ_Q1   = 16'd9000;
    localparam logic [15:0] AZ_Q2   = 16'd18000;
    localparam logic [15:0] AZ_Q3   = 16'd27000;

    typedef struct packed {
        logic [15:0] distance;
        logic [15:0] azimuth;
        logic [7:0]  intensity;
        logic [3:0]  laser;
        logic [3:0]  block;
    } t_task;

    function automatic logic signed [15:0] vert_cos(input logic [3:0] idx);
        logic signed [15:0] v;
        unique case (idx)
            4'd0:  v = 16'sd31651;
            4'd1:  v = 16'sd32763;
            4'd2:  v = 16'sd31928;
            4'd3:  v = 16'sd32723;
            4'd4:  v = 16'sd32166;
            4'd5:  v = 16'sd32643;
            4'd6:  v = 16'sd32365;
            4'd7:  v = 16'sd32524;
            4'd8:  v = 16'sd32449;
            4'd9:  v = 16'sd32748;
            4'd10: v = 16'sd32270;
            4'd11: v = 16'sd32688;
            4'd12: v = 16'sd32052;
            4'd13: v = 16'sd32588;
            4'd14: v = 16'sd31795;
            default: v = 16'sd32767;
        endcase
        return v;
    endfunction

    // Entry 15 is exactly 1.0, which needs 17 bits; cosine is returned wide.
    function automatic logic signed [16:0] vert_cos_w(input logic [3:0] idx);
        return (idx == 4'd15) ? 17'sd32768 : 17'(vert_cos(idx));
    endfunction

    function automatic logic signed [15:0] vert_sin(input logic [3:0] idx);
        logic signed [15:0] v;
        unique case (idx)
            4'd0:  v = -16'sd8481;
            4'd1:  v = 16'sd572;
            4'd2:  v = -16'sd7371;
            4'd3:  v = -16'sd1715;
            4'd4:  v = -16'sd6252;
            4'd5:  v = -16'sd2856;
            4'd6:  v = -16'sd5126;
            4'd7:  v = -16'sd3993;
            4'd8:  v = 16'sd4560;
            4'd9:  v = 16'sd1144;
            4'd10: v = 16'sd5690;
            4'd11: v = 16'sd2286;
            4'd12: v = 16'sd6813;
            4'd13: v = 16'sd3425;
            4'd14: v = 16'sd7927;
            default: v = 16'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [24:0] cordic_atan(input logic [3:0] idx);
        logic signed [24:0] v;
        unique case (idx)
            4'd0:  v = 25'sd1152000;
            4'd1:  v = 25'sd680065;
            4'd2:  v = 25'sd359328;
            4'd3:  v = 25'sd182400;
            4'd4:  v = 25'sd91554;
            4'd5:  v = 25'sd45822;
            4'd6:  v = 25'sd22916;
            4'd7:  v = 25'sd11459;
            4'd8:  v = 25'sd5730;
            4'd9:  v = 25'sd2865;
            4'd10: v = 25'sd1432;
            4'd11: v = 25'sd716;
            4'd12: v = 25'sd358;
            4'd13: v = 25'sd179;
            4'd14: v = 25'sd90;
            default: v = 25'sd45;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/lidar_packet_to_xyz.sv */
// Top level of the lidar packet decoder: byte stream in, Cartesian points out.
//
//   channel  | ports                                   | transfer when
//   ---------+-----------------------------------------+------------------------
//   bytes in | i_data_byte, i_packet_last              | i_push && !o_full
//   points   | o_x_mm, o_y_mm, o_z_mm, o_return_...    | i_pop && !o_empty
//
// Bytes are taken at one per cycle unless o_full; a byte that completes a point queues a task.
// Each point steps through the engine states QUAD, CORDIC (the 16-step azimuth CORDIC), MAP, MUL1, MUL2, ROUND.
// A four-entry task queue absorbs points that arrive faster than the engine takes them.
// o_full rises while the queue is full; reset is synchronous and empties everything.
module lidar_packet_to_xyz #(
    parameter int BLOCKS_PER_PACKET = lptx_pkg::BLOCKS_PER_PACKET,
    parameter int BYTES_PER_BLOCK   = lptx_pkg::BYTES_PER_BLOCK,
    parameter int RETURNS_PER_BLOCK = lptx_pkg::RETURNS_PER_BLOCK,
    parameter int LASERS_USED       = lptx_pkg::LASERS_USED
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_packet_last,
    input  logic               i_pop,
    output logic               o_empty,
    output logic signed [17:0] o_x_mm,
    output logic signed [17:0] o_y_mm,
    output logic signed [17:0] o_z_mm,
    output logic [7:0]         o_return_intensity,
    output logic [3:0]         o_laser_number,
    output logic [3:0]         o_block_number
);
    import lptx_pkg::*;

    logic  task_valid, q_empty, q_pop, accept;
    t_task task_in, task_out;

    assign accept = i_push && !o_full;

    lptx_front #(
        .BLOCKS_PER_PACKET(BLOCKS_PER_PACKET),
        .BYTES_PER_BLOCK(BYTES_PER_BLOCK),
        .RETURNS_PER_BLOCK(RETURNS_PER_BLOCK),
        .LASERS_USED(LASERS_USED)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_accept(accept),
        .i_data_byte(i_data_byte), .i_packet_last(i_packet_last),
        .o_task_valid(task_valid), .o_task(task_in)
    );

    lptx_fifo u_fifo (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(task_valid), .i_data(task_in),
        .i_pop(q_pop), .o_full(o_full), .o_empty(q_empty), .o_data(task_out)
    );

    lptx_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_task_empty(q_empty), .i_task(task_out),
        .o_task_pop(q_pop), .i_pop(i_pop), .o_empty(o_empty),
        .o_x_mm(o_x_mm), .o_y_mm(o_y_mm), .o_z_mm(o_z_mm),
        .o_return_intensity(o_return_intensity),
        .o_laser_number(o_laser_number), .o_block_number(o_block_number)
    );

endmodule

/* hw/rtl/lptx_front.sv */
// Front end: tracks the packet position, assembles fields and issues point tasks.
module lptx_front #(
    parameter int BLOCKS_PER_PACKET = 12,
    parameter int BYTES_PER_BLOCK   = 100,
    parameter int RETURNS_PER_BLOCK = 32,
    parameter int LASERS_USED       = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [7:0]           i_data_byte,
    input  logic                 i_packet_last,
    output logic                 o_task_valid,
    output lptx_pkg::t_task      o_task
);
    import lptx_pkg::*;

    localparam int TOTAL = BLOCKS_PER_PACKET * BYTES_PER_BLOCK;
    localparam int LIM   = (LASERS_USED < 16) ? LASERS_USED : 16;

    logic [10:0] r_pos, n_pos;
    logic [4:0]  r_blk, n_blk;
    logic [7:0]  r_off, n_off;
    logic [6:0]  r_ret, n_ret;
    logic [1:0]  r_ph, n_ph;
    logic [15:0] r_az, n_az;
    logic [15:0] r_dist, n_dist;
    logic        in_range;

    always_comb begin
        in_range = (r_pos != POS_MAX) && ({2'b00, r_pos} < 13'(TOTAL));
        n_pos  = r_pos;
        n_blk  = r_blk;
        n_off  = r_off;
        n_ret  = r_ret;
        n_ph   = r_ph;
        n_az   = r_az;
        n_dist = r_dist;
        o_task_valid = 1'b0;
        o_task.distance  = r_dist;
        o_task.azimuth   = r_az;
        o_task.intensity = i_data_byte;
        o_task.laser     = r_ret[3:0];
        o_task.block     = r_blk[3:0];
        if (i_accept) begin
            if (in_range) begin
                if (r_off == 8'd2) begin
                    n_az = {r_az[15:8], i_data_byte};
                end else if (r_off == 8'd3) begin
                    n_az = {i_data_byte, r_az[7:0]};
                end else if (r_off >= 8'd4 && r_ret < 7'(RETURNS_PER_BLOCK)) begin
                    if (r_ph == 2'd0) begin
                        n_dist = {r_dist[15:8], i_data_byte};
                    end else if (r_ph == 2'd1) begin
                        n_dist = {i_data_byte, r_dist[7:0]};
                    end else if (r_ret < 7'(LIM)) begin
                        o_task_valid = 1'b1;
                    end
                end
            end
            if (i_packet_last) begin
                n_pos = '0;
                n_blk = '0;
                n_off = '0;
                n_ret = '0;
                n_ph  = '0;
            end else if (r_pos != POS_MAX) begin
                n_pos = r_pos + 11'd1;
                if (r_off == 8'(BYTES_PER_BLOCK - 1)) begin
                    n_off = '0;
                    n_blk = r_blk + 5'd1;
                end else begin
                    n_off = r_off + 8'd1;
                end
                if (r_off == 8'(BYTES_PER_BLOCK - 1) || r_off < 8'd4) begin
                    n_ret = '0;
                    n_ph  = '0;
                end else if (r_ph == 2'd2) begin
                    n_ph  = '0;
                    n_ret = r_ret + 7'd1;
                end else begin
                    n_ph = r_ph + 2'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_blk  <= '0;
            r_off  <= '0;
            r_ret  <= '0;
            r_ph   <= '0;
            r_az   <= '0;
            r_dist <= '0;
        end else begin
            r_pos  <= n_pos;
            r_blk  <= n_blk;
            r_off  <= n_off;
            r_ret  <= n_ret;
            r_ph   <= n_ph;
            r_az   <= n_az;
            r_dist <= n_dist;
        end
    end

endmodule

/* hw/rtl/lptx_fifo.sv */
// Short task queue between the front end and the point engine.
module lptx_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lptx_pkg::t_task i_data,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_empty,
    output lptx_pkg::t_task o_data
);
    import lptx_pkg::*;

    t_task       r_mem [4];
    logic [1:0]  r_wr, r_rd;
    logic [2:0]  r_cnt;
    logic        do_push, do_pop;

    assign o_full  = (r_cnt == 3'd4);
    assign o_empty = (r_cnt == 3'd0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + 2'd1;
            end
            if (do_pop) begin
                r_rd <= r_rd + 2'd1;
            end
            r_cnt <= r_cnt + 3'(do_push) - 3'(do_pop);
        end
    end

endmodule

/* hw/rtl/lptx_back.sv */
// Point engine: azimuth CORDIC, projection multiplies, rounding and result register.
module lptx_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_task_empty,
    input  lptx_pkg::t_task i_task,
    output logic            o_task_pop,
    input  logic            i_pop,
    output logic            o_empty,
    output logic signed [17:0] o_x_mm,
    output logic signed [17:0] o_y_mm,
    output logic signed [17:0] o_z_mm,
    output logic [7:0]      o_return_intensity,
    output logic [3:0]      o_laser_number,
    output logic [3:0]      o_block_number
);
    import lptx_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE, ST_QUAD, ST_CORDIC, ST_MAP, ST_MUL1, ST_MUL2, ST_ROUND
    } t_state;

    t_state r_state;
    t_task  r_task;
    logic [1:0]  r_quad;
    logic [3:0]  r_iter;
    logic signed [32:0] r_x, r_y;
    logic signed [24:0] r_z;
    logic signed [15:0] r_ca, r_sa;
    logic signed [33:0] r_p1, r_pz;
    logic signed [49:0] r_px, r_py;
    logic r_out_valid;

    logic signed [32:0] dx, dy, qc, qs;
    logic signed [15:0] c15, s15;
    logic [15:0] az_mod;
    logic [15:0] az_res;
    logic [1:0]  az_quad;
    logic [49:0] mag_x, mag_y;
    logic [33:0] mag_z;
    logic [17:0] rx, ry, rz;
    logic out_free;

    assign o_task_pop = (r_state == ST_IDLE) && !i_task_empty;
    assign o_empty    = !r_out_valid;
    assign out_free   = !r_out_valid || i_pop;

    always_comb begin
        az_mod = (r_task.azimuth >= AZ_FULL) ? r_task.azimuth - AZ_FULL : r_task.azimuth;
        priority if (az_mod >= AZ_Q3) begin
            az_quad = 2'd3;
            az_res  = az_mod - AZ_Q3;
        end else if (az_mod >= AZ_Q2) begin
            az_quad = 2'd2;
            az_res  = az_mod - AZ_Q2;
        end else if (az_mod >= AZ_Q1) begin
            az_quad = 2'd1;
            az_res  = az_mod - AZ_Q1;
        end else begin
            az_quad = 2'd0;
            az_res  = az_mod;
        end
        dx = r_y >>> r_iter;
        dy = r_x >>> r_iter;
        qc = (r_x + 33'sd16384) >>> 15;
        qs = (r_y + 33'sd16384) >>> 15;
        c15 = (qc < 0) ? 16'sd0 : (qc > 33'sd32767) ? 16'sd32767 : 16'(qc);
        s15 = (qs < 0) ? 16'sd0 : (qs > 33'sd32767) ? 16'sd32767 : 16'(qs);
        mag_x = r_px[49] ? 50'(-r_px) : 50'(r_px);
        mag_y = r_py[49] ? 50'(-r_py) : 50'(r_py);
        mag_z = r_pz[33] ? 34'(-r_pz) : 34'(r_pz);
        rx = 18'((mag_x + 50'd536870912) >> 30);
        ry = 18'((mag_y + 50'd536870912) >> 30);
        rz = 18'((mag_z + 34'd16384) >> 15);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_iter      <= '0;
        end else begin
            if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_task_empty) begin
                        r_task  <= i_task;
                        r_state <= ST_QUAD;
                    end
                end
                ST_QUAD: begin
                    r_quad  <= az_quad;
                    r_state <= ST_CORDIC;
                    r_iter  <= '0;
                    r_x     <= CORDIC_GAIN_Q30;
                    r_y     <= '0;
                    r_z     <= 25'($signed({1'b0, az_res[13:0], 8'b0}));
                end
                ST_CORDIC: begin
                    if (!r_z[24]) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - cordic_atan(r_iter);
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + cordic_atan(r_iter);
                    end
                    r_iter <= r_iter + 4'd1;
                    if (r_iter == 4'(CORDIC_STEPS - 1)) begin
                        r_state <= ST_MAP;
                    end
                end
                ST_MAP: begin
                    unique case (r_quad)
                        2'd0: begin r_ca <= c15;  r_sa <= s15;  end
                        2'd1: begin r_ca <= -s15; r_sa <= c15;  end
                        2'd2: begin r_ca <= -c15; r_sa <= -s15; end
                        default: begin r_ca <= s15; r_sa <= -c15; end
                    endcase
                    r_state <= ST_MUL1;
                end
                ST_MUL1: begin
                    r_p1 <= 34'($signed({1'b0, r_task.distance, 1'b0})
                                * vert_cos_w(r_task.laser));
                    r_pz <= 34'($signed({1'b0, r_task.distance, 1'b0})
                                * vert_sin(r_task.laser));
                    r_state <= ST_MUL2;
                end
                ST_MUL2: begin
                    r_px    <= 50'(r_p1 * r_ca);
                    r_py    <= 50'(r_p1 * r_sa);
                    r_state <= ST_ROUND;
                end
                ST_ROUND: begin
                    if (out_free) begin
                        o_x_mm <= r_px[49] ? -$signed(rx) : $signed(rx);
                        o_y_mm <= r_py[49] ? -$signed(ry) : $signed(ry);
                        o_z_mm <= r_pz[33] ? -$signed(rz) : $signed(rz);
                        o_return_intensity <= r_task.intensity;
                        o_laser_number     <= r_task.laser;
                        o_block_number     <= r_task.block;
                        r_out_valid        <= 1'b1;
                        r_state            <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

endmodule

/* hw/rtl/lptx_checker.sv */
// Port-level assertions for the lidar packet decoder, bound to the top level.
module lptx_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_pop,
    input logic               o_empty,
    input logic signed [17:0] o_x_mm,
    input logic signed [17:0] o_z_mm,
    input logic [3:0]         o_laser_number,
    input logic [3:0]         o_block_number
);
    import lptx_pkg::*;

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty)
        else $error("result present after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !i_pop) |=> (!o_empty && $stable(o_x_mm) && $stable(o_z_mm)
                                  && $stable(o_laser_number) && $stable(o_block_number)))
        else $error("stalled result changed");

    a_block: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_block_number < 4'(BLOCKS_PER_PACKET)))
        else $error("block number out of range");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (o_x_mm <= 18'sd131070 && o_x_mm >= -18'sd131070
                      && o_z_mm <= 18'sd131070 && o_z_mm >= -18'sd131070))
        else $error("coordinate out of range");

endmodule

bind lidar_packet_to_xyz lptx_checker u_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pop(i_pop), .o_empty(o_empty),
    .o_x_mm(o_x_mm), .o_z_mm(o_z_mm),
    .o_laser_number(o_laser_number), .o_block_number(o_block_number)
);

/* verif/lidar_packet_to_xyz_tb.sv */
// Self-checking testbench of the lidar packet decoder: byte stream in, points checked.
module lidar_packet_to_xyz_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lptx_pkg::*;

    typedef struct {
        logic signed [17:0] x;
        logic signed [17:0] y;
        logic signed [17:0] z;
        logic [7:0]         inten;
        logic [3:0]         laser;
        logic [3:0]         blk;
    } t_point;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_push = 1'b0;
    logic               o_full;
    logic [7:0]         i_data_byte = 8'd0;
    logic               i_packet_last = 1'b0;
    logic               i_pop = 1'b0;
    logic               o_empty;
    logic signed [17:0] o_x_mm, o_y_mm, o_z_mm;
    logic [7:0]         o_return_intensity;
    logic [3:0]         o_laser_number, o_block_number;

    t_point      point_queue[$];
    int          error_count = 0;
    int          cycle_count = 0;
    int          send_idle = 0;
    int          recv_idle = 0;
    logic [10:0] pos_q = '0;
    logic [15:0] az_q = '0;
    logic [15:0] dist_q = '0;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PKT_BYTES = BLOCKS_PER_PACKET * BYTES_PER_BLOCK;

    lidar_packet_to_xyz dut (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("lidar_packet_to_xyz_tb: errors");
            $finish;
        end
    end

    function automatic longint fshift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint rshift(longint v, int s);
        longint m;
        longint r;
        m = (v < 0) ? -v : v;
        r = (m + (longint'(1) << (s - 1))) >> s;
        return (v < 0) ? -r : r;
    endfunction

    function automatic longint to_q15(longint v);
        longint q;
        q = fshift(v + 16384, 15);
        if (q < 0) q = 0;
        if (q > 32767) q = 32767;
        return q;
    endfunction

    task automatic azimuth_sin_cos(input logic [15:0] az, output longint ca, output longint sa);
        longint a, quad, z, x, y, dx, dy, c, s;
        longint atan_tab[16] = '{1152000, 680065, 359328, 182400, 91554, 45822, 22916,
                                 11459, 5730, 2865, 1432, 716, 358, 179, 90, 45};
        a = az % 36000;
        quad = a / 9000;
        z = (a % 9000) * 256;
        x = 652032874;
        y = 0;
        for (int i = 0; i < 16; i++) begin
            dx = fshift(y, i);
            dy = fshift(x, i);
            if (z >= 0) begin
                x -= dx; y += dy; z -= atan_tab[i];
            end else begin
                x += dx; y -= dy; z += atan_tab[i];
            end
        end
        c = to_q15(x);
        s = to_q15(y);
        case (quad)
            0: begin ca = c; sa = s; end
            1: begin ca = -s; sa = c; end
            2: begin ca = -c; sa = -s; end
            default: begin ca = s; sa = -c; end
        endcase
    endtask

    task automatic predict_point(input logic [7:0] b, input logic last);
        longint vc[16] = '{31651, 32763, 31928, 32723, 32166, 32643, 32365, 32524,
                           32449, 32748, 32270, 32688, 32052, 32588, 31795, 32768};
        longint vs[16] = '{-8481, 572, -7371, -1715, -6252, -2856, -5126, -3993,
                           4560, 1144, 5690, 2286, 6813, 3425, 7927, 0};
        int off, k, ret, ph;
        longint ca, sa, mm;
        t_point p;
        if (pos_q < POS_MAX && pos_q < PKT_BYTES) begin
            off = pos_q % BYTES_PER_BLOCK;
            if (off == 2) az_q[7:0] = b;
            else if (off == 3) az_q[15:8] = b;
            else if (off >= 4) begin
                k = off - 4;
                ret = k / 3;
                ph = k % 3;
                if (ret < RETURNS_PER_BLOCK) begin
                    if (ph == 0) dist_q[7:0] = b;
                    else if (ph == 1) dist_q[15:8] = b;
                    else if (ret < LASERS_USED && ret < 16) begin
                        azimuth_sin_cos(az_q, ca, sa);
                        mm = longint'(dist_q) * 2;
                        p.x = 18'(rshift(mm * vc[ret] * ca, 30));
                        p.y = 18'(rshift(mm * vc[ret] * sa, 30));
                        p.z = 18'(rshift(mm * vs[ret], 15));
                        p.inten = b;
                        p.laser = 4'(ret);
                        p.blk = 4'(pos_q / BYTES_PER_BLOCK);
                        point_queue.insert(point_queue.size(), p);
                    end
                end
            end
        end
        if (last) pos_q = '0;
        else if (pos_q < POS_MAX) pos_q = pos_q + 1'b1;
    endtask

    task automatic send_byte(input logic [7:0] b, input logic last);
        while (send_idle > 0 && $urandom_range(99) < send_idle) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_data_byte <= b;
        i_packet_last <= last;
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        predict_point(b, last);
    endtask

    always @(posedge i_clk) begin
        t_point p;
        if (i_pop && !o_empty) begin
            if (point_queue.size() == 0) begin
                $error("point transfer with nothing expected");
                error_count++;
            end else begin
                p = point_queue.pop_front();
                if (o_x_mm !== p.x) begin
                    $error("x_mm expected %0d actual %0d", p.x, o_x_mm); error_count++;
                end
                if (o_y_mm !== p.y) begin
                    $error("y_mm expected %0d actual %0d", p.y, o_y_mm); error_count++;
                end
                if (o_z_mm !== p.z) begin
                    $error("z_mm expected %0d actual %0d", p.z, o_z_mm); error_count++;
                end
                if (o_return_intensity !== p.inten) begin
                    $error("return_intensity expected %0d actual %0d", p.inten,
                           o_return_intensity);
                    error_count++;
                end
                if (o_laser_number !== p.laser) begin
                    $error("laser_number expected %0d actual %0d", p.laser, o_laser_number);
                    error_count++;
                end
                if (o_block_number !== p.blk) begin
                    $error("block_number expected %0d actual %0d", p.blk, o_block_number);
                    error_count++;
                end
            end
        end
        i_pop <= (recv_idle == 0) || ($urandom_range(99) >= recv_idle);
    end

    task automatic wait_drained();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (point_queue.size() != 0) @(posedge i_clk);
    endtask

    // Sends a packet with one azimuth; distances come from the mode argument.
    task automatic send_packet(input logic [15:0] az, input int mode, input int len);
        logic [7:0] b;
        int off;
        for (int i = 0; i < len; i++) begin
            off = i % BYTES_PER_BLOCK;
            if (off == 2) b = az[7:0];
            else if (off == 3) b = az[15:8];
            else if (mode == 0) b = 8'hFF;
            else if (mode == 1) b = 8'h00;
            else b = 8'($urandom);
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic test_directed();
        // Largest distances at the quadrant edges, zero distances at 9000, and wrapped azimuths.
        send_packet(16'd0, 0, 4 + 3 * 16);
        send_packet(16'd8999, 0, 4 + 3 * 3);
        send_packet(16'd9000, 1, 4 + 3 * 2);
        send_packet(16'd27000, 0, 4 + 3 * 2);
        send_packet(16'hFFFF, 0, 4 + 3 * 2);
        send_packet(16'd36000, 2, 4 + 3 * 1 + 1);
        wait_drained();
    endtask

    task automatic test_full_packet();
        // Several blocks in one packet, including the ignored returns of the two full blocks.
        send_packet(16'($urandom_range(65535)), 2, 2 * BYTES_PER_BLOCK + 50);
        wait_drained();
    endtask

    task automatic test_random();
        int n;
        int len;
        n = 0;
        while (n < 50) begin
            if ($urandom_range(9) < 8) begin
                len = 4 + $urandom_range(3 * 20);
                send_packet(16'($urandom), 2, len);
                n += len;
            end else begin
                send_byte(8'($urandom), 1'($urandom_range(1)));
                n++;
            end
            if ($urandom_range(15) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        send_idle = 12; recv_idle = 76;
        test_random();
        send_idle = 76; recv_idle = 12;
        test_full_packet();
        test_random();
        send_idle = 0; recv_idle = 0;
        test_random();
        wait_drained();
        repeat (100) @(posedge i_clk);
        if (error_count == 0 && point_queue.size() == 0) begin
            $display("lidar_packet_to_xyz_tb: clean");
        end else begin
            $display("lidar_packet_to_xyz_tb: errors");
        end
        $finish;
    end
endmodule
